### hdl/dxt_pkg.sv
`timescale 1ns / 1ps

package dxt_pkg;

  localparam int unsigned MAX_BLOCKS_WIDE = 1024;
  localparam int unsigned MAX_BLOCKS_HIGH = 1024;

  localparam int unsigned CFG_SIZE_W  = 11;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned ADDR_W      = 24;

  localparam int unsigned COL_W = (MAX_BLOCKS_WIDE > 1) ? $clog2(MAX_BLOCKS_WIDE) : 1;
  localparam int unsigned ROW_W = (MAX_BLOCKS_HIGH > 1) ? $clog2(MAX_BLOCKS_HIGH) : 1;
  localparam int unsigned POS_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int unsigned CMP_W = ((POS_W > CFG_SIZE_W) ? POS_W : CFG_SIZE_W) + 1;

  typedef enum logic [1:0] {
    MODE_DXT1     = 2'd0,
    MODE_DXT5     = 2'd1,
    MODE_NO_ALPHA = 2'd2
  } mode_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DECODE_MODE      = 2'd0,
    CFG_WIDTH_IN_BLOCKS  = 2'd1,
    CFG_HEIGHT_IN_BLOCKS = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [7:0]  alpha_first;
    logic [7:0]  alpha_second;
    logic [47:0] alpha_codes;
    logic [15:0] colour_first;
    logic [15:0] colour_second;
    logic [31:0] colour_codes;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic              alpha_write;
    logic              block_last;
    logic              image_last;
  } out_word_t;

  typedef struct packed {
    logic [3:0][7:0] red;
    logic [3:0][7:0] green;
    logic [3:0][7:0] blue;
    logic [7:0][7:0] alpha;
    logic            alpha_write;
  } palette_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] rows_left;
    logic             last;
  } pos_t;

  typedef struct packed {
    palette_t    palette;
    logic [31:0] colour_codes;
    logic [47:0] alpha_codes;
    pos_t        pos;
  } block_t;

  function automatic logic [CFG_SIZE_W-1:0] sat_size(input logic [CFG_SIZE_W-1:0] v,
                                                      input int unsigned maxv);
    if (v == '0) begin
      return CFG_SIZE_W'(1);
    end
    if (32'(v) > maxv) begin
      return CFG_SIZE_W'(maxv);
    end
    return v;
  endfunction

endpackage

### hdl/dxt_palette.sv
`timescale 1ns / 1ps

module dxt_palette import dxt_pkg::*; (
  input  in_word_t in_word_i,
  input  mode_e    mode_i,
  output palette_t palette_o
);

  function automatic logic [7:0] div7(input logic [10:0] n);
    logic [22:0] m;
    m = 23'(n) * 23'(2341);
    return m[21:14];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] n);
    logic [22:0] m;
    m = 23'(n) * 23'(3277);
    return m[21:14];
  endfunction

  logic [4:0]      r0, r1, b0, b1;
  logic [5:0]      g0, g1;
  logic [7:0]      a0, a1;
  logic            a_gt;
  logic [7:0][7:0] dxt5_lvl;

  assign r0   = in_word_i.colour_first[15:11];
  assign g0   = in_word_i.colour_first[10:5];
  assign b0   = in_word_i.colour_first[4:0];
  assign r1   = in_word_i.colour_second[15:11];
  assign g1   = in_word_i.colour_second[10:5];
  assign b1   = in_word_i.colour_second[4:0];
  assign a0   = in_word_i.alpha_first;
  assign a1   = in_word_i.alpha_second;
  assign a_gt = a0 > a1;

  for (genvar v = 0; v < 4; v++) begin : g_colour
    logic [6:0]  sr, sb;
    logic [7:0]  sg;
    logic [13:0] pr, pg, pb;
    assign sr = 7'(r0) * 7'(3 - v) + 7'(r1) * 7'(v);
    assign sb = 7'(b0) * 7'(3 - v) + 7'(b1) * 7'(v);
    assign sg = 8'(g0) * 8'(3 - v) + 8'(g1) * 8'(v);
    assign pr = 14'(sr) * 14'd85;
    assign pb = 14'(sb) * 14'd85;
    assign pg = 14'(sg) * 14'd85;
    assign palette_o.red[v]   = pr[12:5];
    assign palette_o.blue[v]  = pb[12:5];
    assign palette_o.green[v] = pg[13:6];
  end

  for (genvar k = 0; k < 8; k++) begin : g_alpha
    if (k == 0) begin : g_first
      assign dxt5_lvl[k] = a0;
    end else if (k == 1) begin : g_second
      assign dxt5_lvl[k] = a1;
    end else begin : g_mix
      logic [10:0] n7;
      logic [7:0]  l5;
      assign n7 = 11'(8 - k) * 11'(a0) + 11'(k - 1) * 11'(a1);
      if (k <= 5) begin : g_six
        logic [10:0] n5;
        assign n5 = 11'(6 - k) * 11'(a0) + 11'(k - 1) * 11'(a1);
        assign l5 = div5(n5);
      end else begin : g_fixed
        assign l5 = (k == 6) ? 8'd0 : 8'd255;
      end
      assign dxt5_lvl[k] = a_gt ? div7(n7) : l5;
    end
  end

  always_comb begin
    unique case (mode_i)
      MODE_DXT1: begin
        palette_o.alpha       = {8{8'hFF}};
        palette_o.alpha_write = 1'b1;
      end
      MODE_DXT5: begin
        palette_o.alpha       = dxt5_lvl;
        palette_o.alpha_write = 1'b1;
      end
      default: begin
        palette_o.alpha       = '0;
        palette_o.alpha_write = 1'b0;
      end
    endcase
  end

endmodule

### hdl/dxt_position.sv
`timescale 1ns / 1ps

module dxt_position import dxt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  logic [CFG_SIZE_W-1:0] width_i,
  input  logic [CFG_SIZE_W-1:0] height_i,
  output pos_t                  pos_o
);

  logic [COL_W-1:0] col_q, col_d, col_eff;
  logic [ROW_W-1:0] row_q, row_d, row_eff;
  logic [CMP_W-1:0] w_x, h_x;
  logic             col_end, row_end;

  assign w_x     = CMP_W'(width_i);
  assign h_x     = CMP_W'(height_i);
  assign col_eff = (CMP_W'(col_q) >= w_x) ? '0 : col_q;
  assign row_eff = (CMP_W'(row_q) >= h_x) ? '0 : row_q;
  assign col_end = CMP_W'(col_eff) == (w_x - CMP_W'(1));
  assign row_end = CMP_W'(row_eff) == (h_x - CMP_W'(1));

  assign pos_o.col       = col_eff;
  assign pos_o.rows_left = ROW_W'(h_x - CMP_W'(1) - CMP_W'(row_eff));
  assign pos_o.last      = col_end && row_end;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_eff + ROW_W'(1);
      end else begin
        col_d = col_eff + COL_W'(1);
        row_d = row_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### hdl/dxt_pixel.sv
`timescale 1ns / 1ps

module dxt_pixel import dxt_pkg::*; (
  input  block_t                blk_i,
  input  logic [3:0]            pix_i,
  input  logic [CFG_SIZE_W-1:0] width_i,
  output out_word_t             word_o
);

  localparam int unsigned PROD_W = ROW_W + 2 + CFG_SIZE_W;

  logic [1:0]        cv;
  logic [2:0]        av;
  logic [ROW_W+1:0]  prow;
  logic [PROD_W-1:0] prod;

  assign cv   = blk_i.colour_codes[{pix_i, 1'b0} +: 2];
  assign av   = blk_i.alpha_codes[6'(pix_i) * 6'd3 +: 3];
  assign prow = {blk_i.pos.rows_left, ~pix_i[3:2]};
  assign prod = PROD_W'(prow) * PROD_W'(width_i);

  assign word_o.pixel_address = ADDR_W'({prod, 2'b00}) + ADDR_W'({blk_i.pos.col, pix_i[1:0]});
  assign word_o.red           = blk_i.palette.red[cv];
  assign word_o.green         = blk_i.palette.green[cv];
  assign word_o.blue          = blk_i.palette.blue[cv];
  assign word_o.alpha         = blk_i.palette.alpha[av];
  assign word_o.alpha_write   = blk_i.palette.alpha_write;
  assign word_o.block_last    = &pix_i;
  assign word_o.image_last    = (&pix_i) && blk_i.pos.last;

endmodule

### hdl/dxt_block_texture_decoder.sv
// An accepted block word is registered into blk_q; its pixel words are then registered into out_q for out_word_o.
// One pixel word per cycle from the pixel counter while out_stall_i does not hold the output, sixteen per block.
// The next block word is taken in the cycle its predecessor issues its last pixel.
// Reset clears the block position to zero, the valid flags and the pixel counter,
// and sets decode_mode 0, width_in_blocks 1 and height_in_blocks 1.
`timescale 1ns / 1ps

module dxt_block_texture_decoder import dxt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_word_t               in_word_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_word_t              out_word_o
);

  mode_e                 mode_q;
  logic [CFG_SIZE_W-1:0] width_q, height_q, w_eff, h_eff;
  palette_t              palette;
  pos_t                  pos_cur;
  block_t                blk_q;
  logic                  blk_valid_q;
  logic [3:0]            pix_q;
  out_word_t             pix_word, out_q;
  logic                  out_valid_q;
  logic                  out_free, pix_fire, blk_done, in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_DXT1;
      width_q  <= CFG_SIZE_W'(1);
      height_q <= CFG_SIZE_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DECODE_MODE:      mode_q   <= mode_e'(cfg_data_i[1:0]);
        CFG_WIDTH_IN_BLOCKS:  width_q  <= cfg_data_i[CFG_SIZE_W-1:0];
        CFG_HEIGHT_IN_BLOCKS: height_q <= cfg_data_i[CFG_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = sat_size(width_q, MAX_BLOCKS_WIDE);
  assign h_eff = sat_size(height_q, MAX_BLOCKS_HIGH);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign pix_fire   = blk_valid_q && out_free;
  assign blk_done   = pix_fire && (&pix_q);
  assign in_stall_o = blk_valid_q && !blk_done;
  assign in_fire    = in_valid_i && !in_stall_o;

  dxt_palette u_palette (
    .in_word_i (in_word_i),
    .mode_i    (mode_q),
    .palette_o (palette)
  );

  dxt_position u_position (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_fire),
    .width_i   (w_eff),
    .height_i  (h_eff),
    .pos_o     (pos_cur)
  );

  dxt_pixel u_pixel (
    .blk_i   (blk_q),
    .pix_i   (pix_q),
    .width_i (w_eff),
    .word_o  (pix_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_valid_q <= 1'b0;
      pix_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        blk_valid_q <= 1'b1;
      end else if (blk_done) begin
        blk_valid_q <= 1'b0;
      end
      if (pix_fire) begin
        pix_q <= pix_q + 4'd1;
      end
      if (out_free) begin
        out_valid_q <= pix_fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      blk_q.palette      <= palette;
      blk_q.colour_codes <= in_word_i.colour_codes;
      blk_q.alpha_codes  <= in_word_i.alpha_codes;
      blk_q.pos          <= pos_cur;
    end
    if (pix_fire) begin
      out_q <= pix_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_idle_counter_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !blk_valid_q |-> pix_q == 4'd0)
    else $error("pixel counter not at zero without a block");

  a_counter_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_done |=> pix_q == 4'd0)
    else $error("pixel counter did not wrap after last pixel");

  a_image_last_on_block_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.image_last |-> out_q.block_last)
    else $error("image_last without block_last");

  a_column_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(pos_cur.col) < CMP_W'(w_eff))
    else $error("block column beyond image width");
`endif

endmodule

### dv/tb_dxt_block_texture_decoder.sv
`timescale 1ns / 1ps

module tb_dxt_block_texture_decoder;
  import dxt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  in_word_t               in_word_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  out_word_t              out_word_o;

  dxt_block_texture_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  out_word_t pending_pixels[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  logic [1:0]            mode_reg;
  logic [CFG_SIZE_W-1:0] blocks_wide;
  logic [CFG_SIZE_W-1:0] blocks_high;
  int unsigned           blk_col;
  int unsigned           blk_row;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned clamp_size(logic [CFG_SIZE_W-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic logic [7:0] lerp_565(int unsigned e0, int unsigned e1, int unsigned v,
                                          int unsigned div);
    return 8'((255 * (e0 * (3 - v) + e1 * v)) / div);
  endfunction

  function automatic void predict_block_pixels(in_word_t blk);
    int unsigned wb, hb, v, av, a0, a1, p;
    int unsigned r0, g0, b0, r1, g1, b1;
    longint unsigned addr;
    logic last_block;
    out_word_t px;
    wb = clamp_size(blocks_wide, MAX_BLOCKS_WIDE);
    hb = clamp_size(blocks_high, MAX_BLOCKS_HIGH);
    if (blk_col >= wb) blk_col = 0;
    if (blk_row >= hb) blk_row = 0;
    last_block = (blk_col == wb - 1) && (blk_row == hb - 1);
    a0 = 32'(blk.alpha_first);
    a1 = 32'(blk.alpha_second);
    r0 = 32'(blk.colour_first[15:11]);
    g0 = 32'(blk.colour_first[10:5]);
    b0 = 32'(blk.colour_first[4:0]);
    r1 = 32'(blk.colour_second[15:11]);
    g1 = 32'(blk.colour_second[10:5]);
    b1 = 32'(blk.colour_second[4:0]);
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 4; i++) begin
        p = 4 * j + i;
        v = 32'(blk.colour_codes[8 * j + 2 * i +: 2]);
        av = 32'(blk.alpha_codes[3 * p +: 3]);
        addr = longint'(4 * hb - 1 - 4 * blk_row - j) * longint'(4 * wb)
             + longint'(4 * blk_col + i);
        px.pixel_address = ADDR_W'(addr);
        px.red = lerp_565(r0, r1, v, 96);
        px.green = lerp_565(g0, g1, v, 192);
        px.blue = lerp_565(b0, b1, v, 96);
        case (mode_reg)
          MODE_DXT1: begin
            px.alpha = 8'hFF;
            px.alpha_write = 1'b1;
          end
          MODE_DXT5: begin
            px.alpha_write = 1'b1;
            if (av == 0) px.alpha = 8'(a0);
            else if (av == 1) px.alpha = 8'(a1);
            else if (a0 > a1) px.alpha = 8'(((8 - av) * a0 + (av - 1) * a1) / 7);
            else if (av <= 5) px.alpha = 8'(((6 - av) * a0 + (av - 1) * a1) / 5);
            else if (av == 6) px.alpha = 8'h00;
            else px.alpha = 8'hFF;
          end
          default: begin
            px.alpha = 8'h00;
            px.alpha_write = 1'b0;
          end
        endcase
        px.block_last = (p == 15);
        px.image_last = (p == 15) && last_block;
        pending_pixels.push_back(px);
      end
    end
    blk_col++;
    if (blk_col >= wb) begin
      blk_col = 0;
      blk_row++;
      if (blk_row >= hb) blk_row = 0;
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic in_word_t random_block();
    in_word_t blk;
    blk.alpha_first = 8'($urandom);
    blk.alpha_second = 8'($urandom);
    blk.alpha_codes = 48'({$urandom, $urandom});
    blk.colour_first = 16'($urandom);
    blk.colour_second = 16'($urandom);
    blk.colour_codes = $urandom;
    return blk;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_DATA_W'(MAX_BLOCKS_WIDE);
      2: return CFG_DATA_W'($urandom_range(0, 2047));
      default: return CFG_DATA_W'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic send_block(input in_word_t blk);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= blk;
    do @(negedge clk_i); while (in_stall_o);
    predict_block_pixels(blk);
    @(posedge clk_i);
  endtask

  task automatic drain_pixels();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DECODE_MODE: mode_reg = data[1:0];
      CFG_WIDTH_IN_BLOCKS: blocks_wide = data;
      CFG_HEIGHT_IN_BLOCKS: blocks_high = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_colour(input logic [15:0] c0, input logic [15:0] c1,
                             input logic [31:0] codes);
    in_word_t blk;
    blk = random_block();
    blk.colour_first = c0;
    blk.colour_second = c1;
    blk.colour_codes = codes;
    send_block(blk);
  endtask

  task automatic send_alpha(input logic [7:0] a0, input logic [7:0] a1,
                            input logic [47:0] codes);
    in_word_t blk;
    blk = random_block();
    blk.alpha_first = a0;
    blk.alpha_second = a1;
    blk.alpha_codes = codes;
    send_block(blk);
  endtask

  task automatic test_reset_state();
    send_colour(16'hFFFF, 16'h0000, 32'hE4E4E4E4);
    send_colour(16'h0000, 16'hFFFF, 32'h1B1B1B1B);
    drain_pixels();
  endtask

  task automatic test_colour_interp();
    write_reg(CFG_WIDTH_IN_BLOCKS, 11'd2);
    write_reg(CFG_HEIGHT_IN_BLOCKS, 11'd2);
    send_colour(16'hF800, 16'h07E0, 32'hE4E4E4E4);
    send_colour(16'h001F, 16'hFFFF, 32'hFFFFFFFF);
    send_colour(16'h0000, 16'h0000, 32'h00000000);
    send_colour(16'hA5A5, 16'h5A5A, 32'h9C9C6363);
    drain_pixels();
  endtask

  task automatic test_dxt5_alpha();
    write_reg(CFG_DECODE_MODE, CFG_DATA_W'(MODE_DXT5));
    send_alpha(8'd200, 8'd10, 48'o7654321076543210);
    send_alpha(8'd10, 8'd200, 48'o7654321076543210);
    send_alpha(8'd77, 8'd77, 48'o0123456701234567);
    send_alpha(8'd255, 8'd0, 48'hFFFFFFFFFFFF);
    send_alpha(8'd0, 8'd255, 48'o7766554433221100);
    drain_pixels();
  endtask

  task automatic test_alpha_modes();
    write_reg(CFG_DECODE_MODE, CFG_DATA_W'(MODE_NO_ALPHA));
    send_block(random_block());
    drain_pixels();
    write_reg(CFG_DECODE_MODE, CFG_DATA_W'(MODE_UNUSED));
    send_block(random_block());
    drain_pixels();
    write_reg(CFG_DECODE_MODE, 11'h7FD);
    send_block(random_block());
    drain_pixels();
    write_reg(CFG_DECODE_MODE, CFG_DATA_W'(MODE_DXT1));
  endtask

  task automatic test_size_limits();
    write_reg(CFG_WIDTH_IN_BLOCKS, 11'd0);
    write_reg(CFG_HEIGHT_IN_BLOCKS, 11'h7FF);
    send_block(random_block());
    send_block(random_block());
    drain_pixels();
    write_reg(CFG_WIDTH_IN_BLOCKS, 11'd1500);
    write_reg(CFG_HEIGHT_IN_BLOCKS, 11'd1024);
    write_reg(CFG_UNUSED_INDEX, 11'd5);
    send_block(random_block());
    send_block(random_block());
    drain_pixels();
  endtask

  task automatic test_size_shrink();
    write_reg(CFG_WIDTH_IN_BLOCKS, 11'd5);
    write_reg(CFG_HEIGHT_IN_BLOCKS, 11'd3);
    repeat (7) send_block(random_block());
    drain_pixels();
    write_reg(CFG_WIDTH_IN_BLOCKS, 11'd2);
    write_reg(CFG_HEIGHT_IN_BLOCKS, 11'd1);
    repeat (3) send_block(random_block());
    drain_pixels();
  endtask

  task automatic test_random_images();
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(CFG_DECODE_MODE, CFG_DATA_W'($urandom_range(0, 2047)));
      write_reg(CFG_WIDTH_IN_BLOCKS, pick_size());
      write_reg(CFG_HEIGHT_IN_BLOCKS, pick_size());
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 9; n++) begin
        send_block(random_block());
        if (phase == 3 && n == 5) drain_pixels();
      end
      drain_pixels();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin : pixel_checker
    out_word_t want;
    int unsigned hold;
    wait (rst_ni);
    forever begin
      hold = rx_steady ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(negedge clk_i); while (out_valid_o !== 1'b1);
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel word %h", out_word_o);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_address", 32'(want.pixel_address),
                    32'(out_word_o.pixel_address));
        check_field("red", 32'(want.red), 32'(out_word_o.red));
        check_field("green", 32'(want.green), 32'(out_word_o.green));
        check_field("blue", 32'(want.blue), 32'(out_word_o.blue));
        check_field("alpha", 32'(want.alpha), 32'(out_word_o.alpha));
        check_field("alpha_write", 32'(want.alpha_write), 32'(out_word_o.alpha_write));
        check_field("block_last", 32'(want.block_last), 32'(out_word_o.block_last));
        check_field("image_last", 32'(want.image_last), 32'(out_word_o.image_last));
      end
      @(posedge clk_i);
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_DECODE_MODE;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    in_word_i <= '0;
    out_stall_i <= 1'b0;
    mode_reg = MODE_DXT1;
    blocks_wide = CFG_SIZE_W'(1);
    blocks_high = CFG_SIZE_W'(1);
    blk_col = 0;
    blk_row = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_colour_interp();
    test_dxt5_alpha();
    test_alpha_modes();
    test_size_limits();
    test_size_shrink();
    test_random_images();

    drain_pixels();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
